[hw/rtl/tcfxa_pkg.sv]
// shared types and constants of the two-class fifo exclusion arbiter
// no dependencies
`default_nettype none

package tcfxa_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int ENTRY_W     = ID_W + 1;
  localparam int OCC_W       = 4;
  localparam int CAP_W       = 4;
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(3);

  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_DEPART = 1'b1;

  typedef enum logic [1:0] {
    EV_ADMIT     = 2'd0,
    EV_DROP      = 2'd1,
    EV_UNDERFLOW = 2'd2
  } event_kind_t;

  typedef enum logic {
    OP_LEAVE = 1'b0,
    OP_ADMIT = 1'b1
  } occ_op_t;

  typedef struct packed {
    logic [OCC_W-1:0] inside_a;
    logic [OCC_W-1:0] inside_b;
  } occ_t;

  typedef struct packed {
    logic ok;
    occ_t occ;
  } occ_res_t;

endpackage

`default_nettype wire

[hw/rtl/two_class_fifo_exclusion_arbiter_core.sv]
// top level of the two-class fifo exclusion arbiter: sequencer, wait queue and output stage
// depends on tcfxa_pkg, tcfxa_ram and tcfxa_occ_unit
`default_nettype none

// Arrivals join a 128-entry wait ring; departures free one place of their class.
// After each item the queue heads are admitted in order while the head's class
// matches the occupants (or nobody is inside), its count is below capacity and
// the item has fewer than 16 results. The block takes one item at a time: an
// item passes accept, head read, check and flush, without the check when the
// queue is empty; each admission adds a head read and check, as the wait ram's
// registered read feeds the shared occupancy check. A waiting downstream stalls
// the block. No clearing pass follows reset; capacity resets to 3.
module two_class_fifo_exclusion_arbiter_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tcfxa_pkg::CAP_W-1:0]   cfg_wdata,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [15:0]                   s_axis_tdata,  // user_id
  input  wire logic [1:0]                    s_axis_tuser,  // req_type, user_class
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [15:0]                   m_axis_tdata,  // person_id
  output logic      [2:0]                    m_axis_tuser,  // event_kind[1:0], person_class
  output logic                               m_axis_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FLUSH
  } state_t;

  state_t                          state;
  logic [tcfxa_pkg::PTR_W-1:0]     head;
  logic [tcfxa_pkg::CNT_W-1:0]     count;
  logic [tcfxa_pkg::RES_W-1:0]     n_res;
  logic [tcfxa_pkg::CAP_W-1:0]     capacity;
  tcfxa_pkg::occ_t                 occ;

  logic                            pend_valid;
  tcfxa_pkg::event_kind_t          pend_kind;
  logic [tcfxa_pkg::ID_W-1:0]      pend_id;
  logic                            pend_cls;

  logic                            accept;
  logic                            arrive;
  logic                            full;
  logic                            out_free;
  logic                            out_load;
  logic [tcfxa_pkg::PTR_W:0]       tail_sum;
  logic [tcfxa_pkg::PTR_W-1:0]     tail;
  logic [tcfxa_pkg::PTR_W-1:0]     head_next;

  logic                            ram_we;
  logic                            ram_re;
  logic [tcfxa_pkg::ENTRY_W-1:0]   ram_rdata;

  tcfxa_pkg::occ_op_t              unit_op;
  logic                            unit_cls;
  tcfxa_pkg::occ_res_t             unit_res;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign arrive        = (s_axis_tuser[0] == tcfxa_pkg::REQ_ARRIVE);
  assign full          = (count == tcfxa_pkg::CNT_W'(tcfxa_pkg::QUEUE_DEPTH));
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = pend_valid && out_free &&
                         (((state == ST_CHECK) && unit_res.ok) || (state == ST_FLUSH));

  always_comb begin
    tail_sum = {1'b0, head} + (tcfxa_pkg::PTR_W + 1)'(count);
    if (tail_sum >= (tcfxa_pkg::PTR_W + 1)'(tcfxa_pkg::QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (tcfxa_pkg::PTR_W + 1)'(tcfxa_pkg::QUEUE_DEPTH);
    end
    tail = tail_sum[tcfxa_pkg::PTR_W-1:0];
    if (head == tcfxa_pkg::PTR_W'(tcfxa_pkg::QUEUE_DEPTH - 1)) begin
      head_next = '0;
    end else begin
      head_next = head + tcfxa_pkg::PTR_W'(1);
    end
  end

  assign ram_we = accept && arrive && !full;
  assign ram_re = (state == ST_READ);

  tcfxa_ram #(
    .WIDTH (tcfxa_pkg::ENTRY_W),
    .DEPTH (tcfxa_pkg::QUEUE_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata ({s_axis_tuser[1], s_axis_tdata}),
    .re    (ram_re),
    .raddr (head),
    .rdata (ram_rdata)
  );

  assign unit_op  = (state == ST_CHECK) ? tcfxa_pkg::OP_ADMIT : tcfxa_pkg::OP_LEAVE;
  assign unit_cls = (state == ST_CHECK) ? ram_rdata[tcfxa_pkg::ID_W] : s_axis_tuser[1];

  tcfxa_occ_unit u_occ (
    .op       (unit_op),
    .cls      (unit_cls),
    .occ      (occ),
    .capacity (capacity),
    .res      (unit_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head          <= '0;
      count         <= '0;
      n_res         <= '0;
      capacity      <= tcfxa_pkg::CAPACITY_RESET;
      occ           <= '0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_READ;
            if (arrive) begin
              if (!full) begin
                count <= count + tcfxa_pkg::CNT_W'(1);
                n_res <= '0;
              end else begin
                pend_valid <= 1'b1;
                pend_kind  <= tcfxa_pkg::EV_DROP;
                pend_id    <= s_axis_tdata;
                pend_cls   <= s_axis_tuser[1];
                n_res      <= tcfxa_pkg::RES_W'(1);
              end
            end else begin
              if (unit_res.ok) begin
                occ   <= unit_res.occ;
                n_res <= '0;
              end else begin
                pend_valid <= 1'b1;
                pend_kind  <= tcfxa_pkg::EV_UNDERFLOW;
                pend_id    <= '0;
                pend_cls   <= s_axis_tuser[1];
                n_res      <= tcfxa_pkg::RES_W'(1);
              end
            end
          end
        end
        ST_READ: begin
          if (count == '0 || n_res == tcfxa_pkg::RES_W'(tcfxa_pkg::MAX_RESULTS)) begin
            state <= ST_FLUSH;
          end else begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!unit_res.ok) begin
            state <= ST_FLUSH;
          end else if (!pend_valid || out_free) begin
            if (pend_valid) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata  <= pend_id;
              m_axis_tuser  <= {pend_cls, pend_kind};
              m_axis_tlast  <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_kind  <= tcfxa_pkg::EV_ADMIT;
            pend_id    <= ram_rdata[tcfxa_pkg::ID_W-1:0];
            pend_cls   <= ram_rdata[tcfxa_pkg::ID_W];
            occ        <= unit_res.occ;
            head       <= head_next;
            count      <= count - tcfxa_pkg::CNT_W'(1);
            n_res      <= n_res + tcfxa_pkg::RES_W'(1);
            state      <= ST_READ;
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= pend_id;
            m_axis_tuser  <= {pend_cls, pend_kind};
            m_axis_tlast  <= 1'b1;
            pend_valid    <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tcfxa_pkg::CNT_W'(tcfxa_pkg::QUEUE_DEPTH))
    else $error("wait count beyond queue depth");

  a_one_class_inside: assert property (@(posedge clk) disable iff (rst)
    !(occ.inside_a != '0 && occ.inside_b != '0))
    else $error("both classes inside at once");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("ready again straight after an accepted item");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending result left over in idle");

  a_admit_needs_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (count != '0))
    else $error("admission check with an empty queue");

endmodule

`default_nettype wire

[hw/rtl/tcfxa_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tcfxa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tcfxa_occ_unit.sv]
// shared occupancy unit: admission check with increment, departure with decrement
// depends on tcfxa_pkg
`default_nettype none

module tcfxa_occ_unit (
  input  wire tcfxa_pkg::occ_op_t             op,
  input  wire logic                           cls,
  input  wire tcfxa_pkg::occ_t                occ,
  input  wire logic [tcfxa_pkg::CAP_W-1:0]    capacity,
  output tcfxa_pkg::occ_res_t                 res
);

  logic [tcfxa_pkg::OCC_W-1:0] own;
  logic [tcfxa_pkg::OCC_W-1:0] other;
  logic [tcfxa_pkg::OCC_W-1:0] own_next;
  logic                        ok;

  always_comb begin
    own      = cls ? occ.inside_b : occ.inside_a;
    other    = cls ? occ.inside_a : occ.inside_b;
    own_next = own;
    ok       = 1'b0;
    case (op)
      tcfxa_pkg::OP_ADMIT: begin
        ok       = (other == '0) && (own < capacity);
        own_next = own + tcfxa_pkg::OCC_W'(1);
      end
      tcfxa_pkg::OP_LEAVE: begin
        ok       = (own != '0);
        own_next = own - tcfxa_pkg::OCC_W'(1);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    res.ok  = ok;
    res.occ = occ;
    if (cls) begin
      res.occ.inside_b = own_next;
    end else begin
      res.occ.inside_a = own_next;
    end
  end

endmodule

`default_nettype wire
